>>> src/eps_pkg.sv
// Shared types, character constants and helper functions for the entry point scanner.
// No dependencies; used by eps_scan, entry_point_scanner_top and the testbench.
package eps_pkg;

    typedef enum logic [3:0] {
        MODE_NORMAL     = 4'd0,
        MODE_SLASH      = 4'd1,
        MODE_LINE       = 4'd2,
        MODE_BLOCK      = 4'd3,
        MODE_BLOCK_STAR = 4'd4,
        MODE_M          = 4'd5,
        MODE_MA         = 4'd6,
        MODE_MAI        = 4'd7,
        MODE_BLANKS     = 4'd8
    } eps_mode_t;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOW_M   = 8'h6D;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_I   = 8'h69;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;

    // One byte handed from the input register to the scanner.
    typedef struct packed {
        logic       fire;
        logic [7:0] text_byte;
        logic       last_byte;
    } eps_step_t;

    function automatic logic is_ident_char(input logic [7:0] c);
        logic res;
        res = ((c >= 8'h61) && (c <= 8'h7A)) ||
              ((c >= 8'h41) && (c <= 8'h5A)) ||
              ((c >= 8'h30) && (c <= 8'h39)) ||
              (c == CH_UNDER);
        return res;
    endfunction

    // Ordinary text handling; prev describes the byte before c.
    function automatic eps_mode_t scan_normal(input logic [7:0] c, input logic prev);
        eps_mode_t m;
        if (c == CH_SLASH)
            m = MODE_SLASH;
        else if ((c == CH_LOW_M) && !prev)
            m = MODE_M;
        else
            m = MODE_NORMAL;
        return m;
    endfunction

endpackage

>>> src/eps_scan.sv
// Scanner state (mode, previous-byte class, found mark) and its one-byte update.
// Depends on eps_pkg.
module eps_scan
(
    input  logic               clk,
    input  logic               rst_n,
    input  eps_pkg::eps_step_t step,
    output logic               found_now
);

    eps_pkg::eps_mode_t mode_reg;
    eps_pkg::eps_mode_t mode_next;
    eps_pkg::eps_mode_t mode_scan;
    logic               prev_reg;
    logic               prev_next;
    logic               found_reg;
    logic               found_next;
    logic               found_scan;
    logic [7:0]         c;

    assign c = step.text_byte;

    always_comb
    begin
        mode_scan  = mode_reg;
        found_scan = found_reg;
        unique case (mode_reg)
            eps_pkg::MODE_SLASH:
            begin
                if (c == eps_pkg::CH_SLASH)
                    mode_scan = eps_pkg::MODE_LINE;
                else if (c == eps_pkg::CH_STAR)
                    mode_scan = eps_pkg::MODE_BLOCK;
                else
                    mode_scan = eps_pkg::scan_normal(c, prev_reg);
            end
            eps_pkg::MODE_LINE:
            begin
                if (c == eps_pkg::CH_NEWLINE)
                    mode_scan = eps_pkg::MODE_NORMAL;
            end
            eps_pkg::MODE_BLOCK:
            begin
                if (c == eps_pkg::CH_STAR)
                    mode_scan = eps_pkg::MODE_BLOCK_STAR;
            end
            eps_pkg::MODE_BLOCK_STAR:
            begin
                if (c == eps_pkg::CH_SLASH)
                    mode_scan = eps_pkg::MODE_NORMAL;
                else if (c != eps_pkg::CH_STAR)
                    mode_scan = eps_pkg::MODE_BLOCK;
            end
            eps_pkg::MODE_M:
            begin
                if (c == eps_pkg::CH_LOW_A)
                    mode_scan = eps_pkg::MODE_MA;
                else
                    mode_scan = eps_pkg::scan_normal(c, prev_reg);
            end
            eps_pkg::MODE_MA:
            begin
                if (c == eps_pkg::CH_LOW_I)
                    mode_scan = eps_pkg::MODE_MAI;
                else
                    mode_scan = eps_pkg::scan_normal(c, prev_reg);
            end
            eps_pkg::MODE_MAI:
            begin
                if (c == eps_pkg::CH_LOW_N)
                    mode_scan = eps_pkg::MODE_BLANKS;
                else
                    mode_scan = eps_pkg::scan_normal(c, prev_reg);
            end
            eps_pkg::MODE_BLANKS:
            begin
                if ((c == eps_pkg::CH_SPACE) || (c == eps_pkg::CH_TAB))
                    mode_scan = eps_pkg::MODE_BLANKS;
                else if (c == eps_pkg::CH_LPAREN)
                begin
                    found_scan = 1'b1;
                    mode_scan  = eps_pkg::MODE_NORMAL;
                end
                else
                    mode_scan = eps_pkg::scan_normal(c, prev_reg);
            end
            default:
                mode_scan = eps_pkg::scan_normal(c, prev_reg);
        endcase
    end

    // Once a match is seen, hold everything until the end of the text.
    assign found_now = found_reg ? 1'b1 : found_scan;

    always_comb
    begin
        mode_next  = mode_reg;
        prev_next  = prev_reg;
        found_next = found_reg;
        if (step.fire)
        begin
            if (step.last_byte)
            begin
                mode_next  = eps_pkg::MODE_NORMAL;
                prev_next  = 1'b0;
                found_next = 1'b0;
            end
            else if (!found_reg)
            begin
                mode_next  = mode_scan;
                prev_next  = eps_pkg::is_ident_char(c);
                found_next = found_scan;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= eps_pkg::MODE_NORMAL;
            prev_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            prev_reg  <= prev_next;
            found_reg <= found_next;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step.fire && step.last_byte |=>
            (mode_reg == eps_pkg::MODE_NORMAL) && !prev_reg && !found_reg)
        else $error("scanner state not cleared after last byte");

    a_found_holds: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && !(step.fire && step.last_byte) |=> found_reg && $stable(mode_reg))
        else $error("found mark or mode changed after a match");

    a_found_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(found_reg) |-> $past(mode_reg) == eps_pkg::MODE_BLANKS)
        else $error("match flagged outside the blank-skipping mode");

endmodule

>>> src/entry_point_scanner_top.sv
// Top level of the entry point scanner: input register, scanner, result register.
// Depends on eps_pkg and eps_scan.
//
// Accepts one text byte per cycle while in_stall is low. Each byte is held in the input
// register and is scanned as it leaves it; the result register loads at that same edge,
// so out_valid and has_main come up from the result register once the last byte has left
// the input register. The scanner state is a registered recurrence, which sets the rate at
// one byte per cycle. Only last bytes wait on the output register: while a result is held
// stalled and the input register holds a last byte, in_stall is raised.
module entry_point_scanner_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       has_main
);

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_last_reg;
    logic               s1_move;
    logic               out_valid_reg;
    logic               has_main_reg;
    logic               found_now;
    eps_pkg::eps_step_t step;

    // A last byte may leave only if the result register is free or draining.
    assign s1_move  = s1_valid_reg && !(s1_last_reg && out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !s1_move;

    assign step.fire      = s1_move;
    assign step.text_byte = s1_byte_reg;
    assign step.last_byte = s1_last_reg;

    eps_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .found_now (found_now)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (s1_move && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= text_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_move && s1_last_reg)
            has_main_reg <= found_now;
    end

    assign out_valid = out_valid_reg;
    assign has_main  = has_main_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_last_reg && out_valid_reg)
        else $error("input stalled without a held result");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && s1_last_reg |=> out_valid_reg)
        else $error("last byte transfer produced no result");

    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !(s1_move && s1_last_reg) |=> !out_valid_reg)
        else $error("result appeared without a last byte");

endmodule

>>> tb/entry_point_scanner_top_tb.sv
// Self-checking testbench for entry_point_scanner_top: drives source texts byte by byte
// and checks each has_main result against an in-bench scanner. Depends on eps_pkg and the RTL.
`timescale 1ns / 1ps

module entry_point_scanner_top_tb;

    localparam int TEXT_BYTES  = 1150;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 8;
    localparam int SHOW_MAX    = 10;

    // Tracks the scanner state per text and holds the has_main values still owed.
    class entry_scoreboard;
        eps_pkg::eps_mode_t mode;
        bit                 prev_ident;
        bit                 found;
        bit                 owed_q[$];
        int                 fail_count;

        function new();
            clear_text();
            fail_count = 0;
        endfunction

        function void clear_text();
            mode       = eps_pkg::MODE_NORMAL;
            prev_ident = 1'b0;
            found      = 1'b0;
        endfunction

        function bit word_char(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9") || (c == eps_pkg::CH_UNDER);
        endfunction

        // Ordinary text; prev_ident still describes the byte before c.
        function eps_pkg::eps_mode_t plain_text(logic [7:0] c);
            if (c == eps_pkg::CH_SLASH)
                return eps_pkg::MODE_SLASH;
            else if (c == eps_pkg::CH_LOW_M && !prev_ident)
                return eps_pkg::MODE_M;
            return eps_pkg::MODE_NORMAL;
        endfunction

        function void advance(logic [7:0] c);
            case (mode)
                eps_pkg::MODE_SLASH:
                    if (c == eps_pkg::CH_SLASH)     mode = eps_pkg::MODE_LINE;
                    else if (c == eps_pkg::CH_STAR) mode = eps_pkg::MODE_BLOCK;
                    else                            mode = plain_text(c);
                eps_pkg::MODE_LINE:
                    if (c == eps_pkg::CH_NEWLINE) mode = eps_pkg::MODE_NORMAL;
                eps_pkg::MODE_BLOCK:
                    if (c == eps_pkg::CH_STAR) mode = eps_pkg::MODE_BLOCK_STAR;
                eps_pkg::MODE_BLOCK_STAR:
                    if (c == eps_pkg::CH_SLASH)     mode = eps_pkg::MODE_NORMAL;
                    else if (c != eps_pkg::CH_STAR) mode = eps_pkg::MODE_BLOCK;
                eps_pkg::MODE_M:
                    mode = (c == eps_pkg::CH_LOW_A) ? eps_pkg::MODE_MA : plain_text(c);
                eps_pkg::MODE_MA:
                    mode = (c == eps_pkg::CH_LOW_I) ? eps_pkg::MODE_MAI : plain_text(c);
                eps_pkg::MODE_MAI:
                    mode = (c == eps_pkg::CH_LOW_N) ? eps_pkg::MODE_BLANKS : plain_text(c);
                eps_pkg::MODE_BLANKS:
                    if (c == eps_pkg::CH_SPACE || c == eps_pkg::CH_TAB)
                        mode = eps_pkg::MODE_BLANKS;
                    else if (c == eps_pkg::CH_LPAREN)
                    begin
                        found = 1'b1;
                        mode  = eps_pkg::MODE_NORMAL;
                    end
                    else
                        mode = plain_text(c);
                default:
                    mode = plain_text(c);
            endcase
            prev_ident = word_char(c);
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            if (!found)
                advance(c);
            if (last)
            begin
                owed_q.push_back(found);
                clear_text();
            end
        endfunction

        function void flag(string what, int want, int got);
            fail_count++;
            if (fail_count <= SHOW_MAX)
                $display("%0t: has_main %s: expected %0d, got %0d", $realtime, what, want, got);
        endfunction

        function void check_result(logic got);
            bit want;
            if (owed_q.size() == 0)
                flag("with no text pending", -1, got);
            else
            begin
                want = owed_q.pop_front();
                if (got !== want)
                    flag("mismatch", want, got);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] text_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_stall;
    logic       has_main;

    entry_scoreboard sb;
    logic [7:0]      text_q[$];
    int              bytes_sent;
    int              sender_idle_pct;
    int              receiver_stall_pct;
    int              quiet_cycles;

    entry_point_scanner_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .has_main  (has_main)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver side: stall at random, decided at each falling edge.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(has_main);
            if (in_valid && !in_stall)
                sb.note_byte(text_byte, last_byte);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("** entry_point_scanner_top: FAILED **");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(logic [7:0] c, logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= c;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    function automatic void push_string(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    // Append one piece of source text; mostly fragments that steer the scanner deep.
    function automatic void push_piece();
        case ($urandom_range(21)) inside
            0, 1:  push_string("main");
            2:     push_string("main(");
            3:     push_string(" main (");
            4:     push_string("(");
            5:     push_string(" ");
            6:     push_string("\t");
            7:     push_string("//");
            8:     push_string("/*");
            9:     push_string("*/");
            10:    push_string("*");
            11:    push_string("/");
            12:    push_string("\n");
            13:    push_string("m");
            14:    push_string("ma");
            15:    push_string("mai");
            16:    push_string("x");
            17:    push_string("_");
            18:    push_string("9");
            19:    push_string("int ");
            default: text_q.push_back(8'($urandom_range(255)));
        endcase
    endfunction

    function automatic void build_text();
        int pieces;
        text_q.delete();
        if ($urandom_range(9) == 0)
        begin
            // noise: raw bytes over the whole code range
            pieces = $urandom_range(12, 1);
            repeat (pieces) text_q.push_back(8'($urandom_range(255)));
        end
        else
        begin
            pieces = $urandom_range(8, 1);
            repeat (pieces) push_piece();
        end
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        sb                 = new();
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        text_byte          = '0;
        last_byte          = 1'b0;
        bytes_sent         = 0;
        quiet_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero and top byte alone, match at start and on the last byte,
        // match right after a block comment, line comment, tab/space gap, ignored tail.
        text_q = {8'h00};
        send_text();
        text_q = {8'hFF};
        send_text();
        text_q.delete();
        push_string("main(");
        send_text();
        text_q.delete();
        push_string("a/**/main (");
        send_text();
        text_q.delete();
        push_string("//m\nmain\t(x");
        send_text();

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct    = (phase == 0) ? 28 : (phase == 1) ? 49 : 0;
            receiver_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 28 : 0;
            while (bytes_sent < (phase + 1) * TEXT_BYTES / 3)
            begin
                build_text();
                send_text();
            end
            // hold off until every owed result has come back
            drain();
        end

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("** entry_point_scanner_top: PASSED **");
        else
            $display("** entry_point_scanner_top: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
src/eps_pkg.sv
src/eps_scan.sv
src/entry_point_scanner_top.sv
tb/entry_point_scanner_top_tb.sv
